// ----- src/rfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rfa_pkg;

    // Internal arithmetic width and result field width
    localparam int DATA_W = 64;
    localparam int RES_W  = 32;
    localparam int FUNC_W = 2;

    localparam int DEF_OPERAND_WIDTH = 16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DIV = 2'd3;

    // Request to the shared reduction unit
    typedef struct packed {
        logic start;
        logic wide;     // 1: full-width quotient, 0: operand-width quotient
    } red_ctl_t;

endpackage

`default_nettype wire

// ----- src/rational_fraction_alu_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fraction ALU: add, subtract, multiply or divide two signed fractions and
// return the result reduced by the gcd of |num| and |den|.
// Input channel (s_valid/s_ready): func and four OPERAND_WIDTH-bit signed
// operands. Result channel (m_valid/m_ready): 32-bit numerator, denominator
// and valid_res, which is low (with both fields zero) for a zero denominator.
// One item is in flight at a time; s_ready is high only while idle.
// Each item is sequenced through one shared reduction unit (binary gcd, one
// step per cycle, then two restoring dividers, one quotient bit per cycle)
// and one OPERAND_WIDTH x OPERAND_WIDTH multiplier used for three products.
// Latency per item is data dependent: both operand reductions and the result
// reduction run in turn, and each is shorter when the gcd search ends early
// or no division is needed. A new item is accepted only in the idle state,
// after the previous result has been handed over.
// The result is held in an output register until taken; a stalled receiver
// keeps the block busy and s_ready low. Synchronous active-low reset returns
// the sequencer and the reduction unit to idle and drops m_valid.
module rational_fraction_alu_top #(
    parameter int OPERAND_WIDTH = rfa_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rfa_pkg::FUNC_W-1:0]        s_func,
    input  logic signed [OPERAND_WIDTH-1:0]   s_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]   s_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]   s_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]   s_b_den,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [rfa_pkg::RES_W-1:0]  m_res_num,
    output logic signed [rfa_pkg::RES_W-1:0]  m_res_den,
    output logic                              m_valid_res
);
    import rfa_pkg::*;

    localparam int W      = OPERAND_WIDTH;
    localparam int PROD_W = 2 * OPERAND_WIDTH;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RED_A = 3'd2;
    localparam logic [2:0] S_RED_B = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_RCHK  = 3'd6;
    localparam logic [2:0] S_RED_R = 3'd7;
    // ST_OUT shares no code with the above: state is 4 bits wide
    localparam logic [3:0] ST_OUT  = 4'd8;

    localparam logic [1:0] MUL_LAST = 2'd2;

    logic [3:0]              state_reg, state_next;
    logic [FUNC_W-1:0]       func_reg, func_next;
    logic signed [W-1:0]     an_reg, an_next;
    logic signed [W-1:0]     ad_reg, ad_next;
    logic signed [W-1:0]     bn_reg, bn_next;
    logic signed [W-1:0]     bd_reg, bd_next;
    logic [1:0]              mcnt_reg, mcnt_next;
    logic signed [PROD_W-1:0] p1_reg, p1_next;
    logic signed [PROD_W-1:0] p2_reg, p2_next;
    logic signed [PROD_W-1:0] p3_reg, p3_next;
    logic [DATA_W-1:0]       rn_reg, rn_next;
    logic [DATA_W-1:0]       rd_reg, rd_next;
    logic [RES_W-1:0]        res_num_reg, res_num_next;
    logic [RES_W-1:0]        res_den_reg, res_den_next;
    logic                    res_ok_reg, res_ok_next;

    logic signed [W-1:0]      mul_x;
    logic signed [W-1:0]      mul_y;
    logic signed [PROD_W-1:0] prod;

    red_ctl_t          red_ctl;
    logic [DATA_W-1:0] red_n;
    logic [DATA_W-1:0] red_d;
    logic              red_done;
    logic [DATA_W-1:0] red_n_out;
    logic [DATA_W-1:0] red_d_out;

    rfa_reduce #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_reduce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (red_ctl),
        .n_in    (red_n),
        .d_in    (red_d),
        .done    (red_done),
        .n_out   (red_n_out),
        .d_out   (red_d_out)
    );

    // single shared multiplier, registered into p1..p3
    assign prod = mul_x * mul_y;

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        mcnt_next    = mcnt_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        p3_next      = p3_reg;
        rn_next      = rn_reg;
        rd_next      = rd_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        res_ok_next  = res_ok_reg;

        red_ctl.start = 1'b0;
        red_ctl.wide  = 1'b0;
        red_n         = DATA_W'(an_reg);
        red_d         = DATA_W'(ad_reg);

        mul_x = an_reg;
        mul_y = bd_reg;

        unique case (state_reg)
            {1'b0, S_IDLE}: begin
                if (s_valid) begin
                    func_next  = s_func;
                    an_next    = s_a_num;
                    ad_next    = s_a_den;
                    bn_next    = s_b_num;
                    bd_next    = s_b_den;
                    state_next = {1'b0, S_CHECK};
                end
            end
            {1'b0, S_CHECK}: begin
                if (ad_reg == '0 || bd_reg == '0) begin
                    // zero operand denominator: no fraction
                    res_num_next = '0;
                    res_den_next = '0;
                    res_ok_next  = 1'b0;
                    state_next   = ST_OUT;
                end else begin
                    red_ctl.start = 1'b1;
                    state_next    = {1'b0, S_RED_A};
                end
            end
            {1'b0, S_RED_A}: begin
                // hold b on the unit inputs so it can start right after a
                red_n = DATA_W'(bn_reg);
                red_d = DATA_W'(bd_reg);
                if (red_done) begin
                    an_next       = red_n_out[W-1:0];
                    ad_next       = red_d_out[W-1:0];
                    red_ctl.start = 1'b1;
                    state_next    = {1'b0, S_RED_B};
                end
            end
            {1'b0, S_RED_B}: begin
                if (red_done) begin
                    bn_next    = red_n_out[W-1:0];
                    bd_next    = red_d_out[W-1:0];
                    mcnt_next  = '0;
                    state_next = {1'b0, S_MUL};
                end
            end
            {1'b0, S_MUL}: begin
                unique case (mcnt_reg)
                    2'd0: begin
                        mul_x   = an_reg;
                        mul_y   = (func_reg == FUNC_MUL) ? bn_reg : bd_reg;
                        p1_next = prod;
                    end
                    2'd1: begin
                        mul_x   = bn_reg;
                        mul_y   = ad_reg;
                        p2_next = prod;
                    end
                    default: begin
                        mul_x   = ad_reg;
                        mul_y   = (func_reg == FUNC_DIV) ? bn_reg : bd_reg;
                        p3_next = prod;
                    end
                endcase
                if (mcnt_reg == MUL_LAST) begin
                    state_next = {1'b0, S_SUM};
                end else begin
                    mcnt_next = mcnt_reg + 2'd1;
                end
            end
            {1'b0, S_SUM}: begin
                unique case (func_reg)
                    FUNC_ADD: rn_next = DATA_W'(p1_reg) + DATA_W'(p2_reg);
                    FUNC_SUB: rn_next = DATA_W'(p1_reg) - DATA_W'(p2_reg);
                    default:  rn_next = DATA_W'(p1_reg);
                endcase
                rd_next    = DATA_W'(p3_reg);
                state_next = {1'b0, S_RCHK};
            end
            {1'b0, S_RCHK}: begin
                red_n = rn_reg;
                red_d = rd_reg;
                if (rd_reg == '0) begin
                    // divide by a zero numerator
                    res_num_next = '0;
                    res_den_next = '0;
                    res_ok_next  = 1'b0;
                    state_next   = ST_OUT;
                end else begin
                    red_ctl.start = 1'b1;
                    red_ctl.wide  = 1'b1;
                    state_next    = {1'b0, S_RED_R};
                end
            end
            {1'b0, S_RED_R}: begin
                if (red_done) begin
                    if (red_d_out[RES_W-1:0] == '0) begin
                        // denominator vanishes in the 32-bit result
                        res_num_next = '0;
                        res_den_next = '0;
                        res_ok_next  = 1'b0;
                    end else begin
                        res_num_next = red_n_out[RES_W-1:0];
                        res_den_next = red_d_out[RES_W-1:0];
                        res_ok_next  = 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold the result until the receiver takes it
                if (m_ready) begin
                    state_next = {1'b0, S_IDLE};
                end
            end
            default: begin
                state_next = {1'b0, S_IDLE};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= {1'b0, S_IDLE};
        end else begin
            state_reg <= state_next;
        end
        func_reg    <= func_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        mcnt_reg    <= mcnt_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        p3_reg      <= p3_next;
        rn_reg      <= rn_next;
        rd_reg      <= rd_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_ok_reg  <= res_ok_next;
    end

    assign s_ready     = (state_reg == {1'b0, S_IDLE});
    assign m_valid     = (state_reg == ST_OUT);
    assign m_res_num   = res_num_reg;
    assign m_res_den   = res_den_reg;
    assign m_valid_res = res_ok_reg;

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("top: ready and result valid together");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_res_num == '0 && m_res_den == '0)
        else $error("top: invalid result with nonzero fields");

    a_valid_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_res |-> m_res_den != '0)
        else $error("top: valid result with zero denominator");

    a_red_start: assert property (@(posedge aclk) disable iff (!aresetn)
        red_ctl.start |=> !red_done)
        else $error("top: reduction finished in the cycle after start");

endmodule

`default_nettype wire

// ----- src/rfa_reduce.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rfa_reduce #(
    parameter int OPERAND_WIDTH = rfa_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rfa_pkg::red_ctl_t           ctl,
    input  logic [rfa_pkg::DATA_W-1:0]  n_in,
    input  logic [rfa_pkg::DATA_W-1:0]  d_in,
    output logic                        done,
    output logic [rfa_pkg::DATA_W-1:0]  n_out,
    output logic [rfa_pkg::DATA_W-1:0]  d_out
);
    import rfa_pkg::*;

    localparam int SHORT_SHIFT = DATA_W - OPERAND_WIDTH;
    localparam int CNT_W       = $clog2(DATA_W + 1);
    localparam int K_W         = $clog2(DATA_W);

    localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(OPERAND_WIDTH);
    localparam logic [CNT_W-1:0] LEN_WIDE  = CNT_W'(DATA_W);

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_GCD  = 2'd1;
    localparam logic [1:0] R_DIV  = 2'd2;

    logic [1:0]        st_reg, st_next;
    logic              done_reg, done_next;
    logic              sn_reg, sn_next;
    logic              sd_reg, sd_next;
    logic              wide_reg, wide_next;
    logic [DATA_W-1:0] qn_reg, qn_next;
    logic [DATA_W-1:0] qd_reg, qd_next;
    logic [DATA_W-1:0] u_reg, u_next;
    logic [DATA_W-1:0] v_reg, v_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [DATA_W-1:0] g_reg, g_next;
    logic [DATA_W-1:0] rn_reg, rn_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb begin
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] trial_n;
        logic [DATA_W-1:0] trial_d;
        logic              ge_n;
        logic              ge_d;

        st_next   = st_reg;
        done_next = 1'b0;
        sn_next   = sn_reg;
        sd_next   = sd_reg;
        wide_next = wide_reg;
        qn_next   = qn_reg;
        qd_next   = qd_reg;
        u_next    = u_reg;
        v_next    = v_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        rn_next   = rn_reg;
        rd_next   = rd_reg;
        cnt_next  = cnt_reg;

        mag_n   = n_in[DATA_W-1] ? (~n_in + DATA_W'(1)) : n_in;
        mag_d   = d_in[DATA_W-1] ? (~d_in + DATA_W'(1)) : d_in;
        trial_n = {rn_reg[DATA_W-2:0], qn_reg[DATA_W-1]};
        trial_d = {rd_reg[DATA_W-2:0], qd_reg[DATA_W-1]};
        ge_n    = (trial_n >= g_reg);
        ge_d    = (trial_d >= g_reg);

        unique case (st_reg)
            R_IDLE: begin
                if (ctl.start) begin
                    sn_next   = n_in[DATA_W-1];
                    sd_next   = d_in[DATA_W-1];
                    qn_next   = mag_n;
                    qd_next   = mag_d;
                    u_next    = mag_n;
                    v_next    = mag_d;
                    k_next    = '0;
                    wide_next = ctl.wide;
                    st_next   = R_GCD;
                end
            end
            R_GCD: begin
                // binary gcd, one step per cycle
                priority if (u_reg == '0) begin
                    // zero numerator: leave the pair as it is
                    st_next   = R_IDLE;
                    done_next = 1'b1;
                end else if (u_reg == v_reg) begin
                    if (u_reg == DATA_W'(1) && k_reg == '0) begin
                        st_next   = R_IDLE;
                        done_next = 1'b1;
                    end else begin
                        g_next   = u_reg << k_reg;
                        rn_next  = '0;
                        rd_next  = '0;
                        cnt_next = wide_reg ? LEN_WIDE : LEN_SHORT;
                        qn_next  = wide_reg ? qn_reg : (qn_reg << SHORT_SHIFT);
                        qd_next  = wide_reg ? qd_reg : (qd_reg << SHORT_SHIFT);
                        st_next  = R_DIV;
                    end
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + K_W'(1);
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (u_reg > v_reg) begin
                    u_next = (u_reg - v_reg) >> 1;
                end else begin
                    v_next = (v_reg - u_reg) >> 1;
                end
            end
            R_DIV: begin
                // two restoring dividers sharing the divisor
                rn_next  = ge_n ? (trial_n - g_reg) : trial_n;
                rd_next  = ge_d ? (trial_d - g_reg) : trial_d;
                qn_next  = {qn_reg[DATA_W-2:0], ge_n};
                qd_next  = {qd_reg[DATA_W-2:0], ge_d};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    st_next   = R_IDLE;
                    done_next = 1'b1;
                end
            end
            default: begin
                st_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= R_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        sn_reg   <= sn_next;
        sd_reg   <= sd_next;
        wide_reg <= wide_next;
        qn_reg   <= qn_next;
        qd_reg   <= qd_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        k_reg    <= k_next;
        g_reg    <= g_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        cnt_reg  <= cnt_next;
    end

    assign done  = done_reg;
    assign n_out = sn_reg ? (~qn_reg + DATA_W'(1)) : qn_reg;
    assign d_out = sd_reg ? (~qd_reg + DATA_W'(1)) : qd_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> st_reg == R_IDLE)
        else $error("reduce: done while busy");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |-> st_reg == R_IDLE)
        else $error("reduce: start while busy");

    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == R_GCD |-> v_reg != '0)
        else $error("reduce: gcd operand went to zero");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == R_DIV |-> g_reg != '0 && rn_reg < g_reg && rd_reg < g_reg)
        else $error("reduce: remainder out of range");

    a_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && $past(st_reg == R_DIV) |-> rn_reg == '0 && rd_reg == '0)
        else $error("reduce: division by gcd not exact");

endmodule

`default_nettype wire
